// ===== hw/rtl/lvu_pkg.sv =====
// ----------------------------------------------------------------------------
// lvu_pkg
// Shared types, register indexes, command codes and fixed-point helpers for
// the Langevin velocity update block.
// ----------------------------------------------------------------------------
package lvu_pkg;

	localparam int IN_W  = 304;
	localparam int OUT_W = 320;

	localparam logic [2:0] REG_TEMPERATURE = 3'd0;
	localparam logic [2:0] REG_TIME_STEP   = 3'd1;
	localparam logic [2:0] REG_LIMIT_DIST  = 3'd2;
	localparam logic [2:0] REG_MODE_FLAGS  = 3'd3;
	localparam logic [2:0] REG_GAMMA0      = 3'd4;

	localparam int MODE_3D    = 0;
	localparam int MODE_DIAM  = 1;
	localparam int MODE_LIMIT = 2;
	localparam int MODE_TALLY = 3;

	localparam logic [63:0] CAP      = 64'h0000_4000_0000_0000;
	localparam logic [63:0] CAP_DIV6 = 64'd11728124029610;
	localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;

	localparam logic signed [65:0] MAX32 = 66'sh0_0000_0000_7FFF_FFFF;
	localparam logic signed [65:0] MIN32 = 66'sh3_FFFF_FFFF_8000_0000;
	localparam logic signed [65:0] MAX64 = 66'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [65:0] MIN64 = 66'sh3_8000_0000_0000_0000;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_GT, OP_DIVQ, OP_DIVR, OP_SQRTC, OP_RC, OP_GV, OP_BD,
		OP_DIVA, OP_ADT, OP_VNEW, OP_MTAL, OP_TERM, OP_TRANS, OP_SQ, OP_SS,
		OP_SQRTS, OP_SPD, OP_CMP, OP_DIVS, OP_VSLO, OP_VSHI, OP_MG, OP_DIVV,
		OP_EDLO, OP_EDHI, OP_EN, OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
		logic       div_start;
		logic       sqrt_start;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic exceed;
		logic limit_en;
		logic tally_en;
		logic last;
	} status_t;

	typedef struct packed {
		logic [30:0] temperature;
		logic [30:0] time_step;
		logic [30:0] limit_distance;
		logic [3:0]  mode_flags;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > MAX32) return 32'sh7FFF_FFFF;
		if (x < MIN32) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [65:0] x);
		if (x > MAX64) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (x < MIN64) return 64'sh8000_0000_0000_0000;
		return x[63:0];
	endfunction

	function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] p,
			input int unsigned k);
		logic signed [63:0] bias;
		bias = p[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (p + bias) >>> k;
	endfunction

endpackage

// ===== hw/rtl/lvu_div.sv =====
// ----------------------------------------------------------------------------
// lvu_div
// Unsigned restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lvu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quot,
	output logic [31:0] rem
);

	logic [63:0] quot_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] sh;
	logic        fit;

	assign sh  = {rem_q, quot_q[63]};
	assign fit = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[62:0], fit};
			rem_q  <= fit ? 32'(sh - {1'b0, dvs_q}) : sh[31:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/lvu_sqrt.sv =====
// ----------------------------------------------------------------------------
// lvu_sqrt
// Integer floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module lvu_sqrt
	import lvu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			res_q <= '0;
			bit_q <= SQRT_TOP;
		end else if (busy_q) begin
			if ({1'b0, n_q} >= trial) begin
				n_q   <= n_q - trial[63:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// ===== hw/rtl/lvu_datapath.sv =====
// ----------------------------------------------------------------------------
// lvu_datapath
// Operand registers, shared multiplier, divider and square root, energy
// state and the result register, driven by controller commands.
// ----------------------------------------------------------------------------
module lvu_datapath
	import lvu_pkg::*;
#(
	parameter int NUM_TYPES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  cfg_t              cfg,
	input  logic [30:0]       gamma [NUM_TYPES],
	input  logic [IN_W-1:0]   in_data,
	input  logic              in_last,
	output logic [OUT_W-1:0]  out_data,
	output logic              out_user
);

	logic signed [31:0] v_q [3];
	logic signed [31:0] f_q [3];
	logic signed [15:0] r_q [3];
	logic signed [31:0] bd_q [3];
	logic signed [31:0] a_q [3];
	logic [30:0]        m_q;
	logic [30:0]        g_q;
	logic               last_q;
	logic signed [63:0] prod_q;
	logic [63:0]        q_q;
	logic [30:0]        rem_q;
	logic [46:0]        x_q;
	logic [30:0]        coeff_q;
	logic signed [63:0] t1_q;
	logic signed [63:0] term_q;
	logic [63:0]        ss_q;
	logic [31:0]        spd_q;
	logic [46:0]        s_q;
	logic [63:0]        acc_q;
	logic [63:0]        mg_q;
	logic               done_q;
	logic signed [63:0] transfer_q;
	logic signed [63:0] reservoir_q;
	logic signed [63:0] extra_q;
	logic [OUT_W-1:0]   out_q;
	logic               out_user_q;

	logic [30:0]        dt;
	logic [30:0]        g_sel;
	logic [30:0]        src;
	logic [30:0]        mass;
	logic signed [31:0] vi, fi, bdi, ai;
	logic signed [15:0] ri;
	logic signed [32:0] vmag;
	logic [63:0]        tmag;
	logic signed [32:0] a_op, b_op;
	logic signed [65:0] prod;
	logic               mul_en;
	logic [63:0]        div_dividend;
	logic [31:0]        div_divisor;
	logic               div_done;
	logic [63:0]        div_quot;
	logic [31:0]        div_rem;
	logic [63:0]        sq_rad;
	logic               sq_done;
	logic [31:0]        sq_root;
	logic signed [32:0] fsum;
	logic signed [49:0] num50;
	logic signed [49:0] mag50;
	logic signed [65:0] qa;
	logic [63:0]        q6;
	logic [63:0]        xs;
	logic signed [63:0] diff;
	logic [31:0]        vq32;
	logic [95:0]        full96;
	logic [79:0]        sh80;
	logic [79:0]        lim80;
	logic [79:0]        r80;
	logic signed [65:0] d66;
	logic               tneg;

	assign dt    = (cfg.time_step == 31'd0) ? 31'd1 : cfg.time_step;
	assign src   = in_data[301:271];
	assign mass  = in_data[126:96];
	assign vi    = v_q[cmd.idx];
	assign fi    = f_q[cmd.idx];
	assign bdi   = bd_q[cmd.idx];
	assign ai    = a_q[cmd.idx];
	assign ri    = r_q[cmd.idx];
	assign vmag  = vi[31] ? -33'(vi) : 33'(vi);
	assign tneg  = transfer_q[63];
	assign tmag  = tneg ? (~transfer_q + 64'd1) : transfer_q;

	always_comb begin
		g_sel = '0;
		if (cfg.mode_flags[MODE_DIAM]) begin
			g_sel = src;
		end else begin
			for (int k = 0; k < NUM_TYPES; k++) begin
				if (src == 31'(k)) g_sel = gamma[k];
			end
		end
	end

	always_comb begin
		mul_en = 1'b1;
		a_op   = '0;
		b_op   = '0;
		case (cmd.op)
			OP_GT: begin
				a_op = {2'b0, g_q};
				b_op = {2'b0, cfg.temperature};
			end
			OP_RC: begin
				a_op = 33'(ri);
				b_op = {2'b0, coeff_q};
			end
			OP_GV: begin
				a_op = {2'b0, g_q};
				b_op = 33'(vi);
			end
			OP_ADT: begin
				a_op = 33'(ai);
				b_op = {2'b0, dt};
			end
			OP_MTAL: begin
				a_op = 33'(bdi);
				b_op = 33'(vi);
			end
			OP_SQ: begin
				a_op = vmag;
				b_op = vmag;
			end
			OP_SPD: begin
				a_op = {1'b0, spd_q};
				b_op = {2'b0, dt};
			end
			OP_VSLO: begin
				a_op = vmag;
				b_op = {1'b0, s_q[31:0]};
			end
			OP_VSHI: begin
				a_op = vmag;
				b_op = {18'b0, s_q[46:32]};
			end
			OP_EDLO: begin
				a_op = {1'b0, tmag[31:0]};
				b_op = {2'b0, dt};
			end
			OP_EDHI: begin
				a_op = {1'b0, tmag[63:32]};
				b_op = {2'b0, dt};
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign prod = a_op * b_op;

	assign fsum  = 33'(fi) + 33'(bdi);
	assign num50 = {fsum[32], fsum, 16'b0};
	assign mag50 = fsum[32] ? -num50 : num50;

	always_comb begin
		div_dividend = '0;
		div_divisor  = {1'b0, dt};
		case (cmd.op)
			OP_DIVQ: div_dividend = prod_q;
			OP_DIVR: div_dividend = 64'({rem_q, 2'b0}) + 64'({rem_q, 1'b0});
			OP_DIVA: begin
				div_dividend = {14'b0, mag50};
				div_divisor  = {1'b0, m_q};
			end
			OP_DIVS: div_dividend = {17'b0, cfg.limit_distance, 16'b0};
			OP_DIVV: begin
				div_dividend = mg_q;
				div_divisor  = spd_q;
			end
			default: div_dividend = '0;
		endcase
	end

	assign sq_rad = (cmd.op == OP_SQRTS) ? ss_q : {1'b0, x_q, 16'b0};

	lvu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	lvu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign qa   = fsum[32] ? -$signed({2'b0, div_quot}) : $signed({2'b0, div_quot});
	assign q6   = {q_q[61:0], 2'b0} + {q_q[62:0], 1'b0};
	assign xs   = q6 + {61'b0, div_quot[2:0]};
	assign diff = t1_q - trunc_shift(prod_q, 16);
	assign vq32 = div_quot[31:0];

	assign full96 = {prod_q, 32'b0} + {32'b0, acc_q};
	assign sh80   = full96[95:16];
	assign lim80  = tneg ? 80'h0000_8000_0000_0000_0000 : 80'h0000_7FFF_FFFF_FFFF_FFFF;
	assign r80    = (sh80 > lim80) ? lim80 : sh80;
	assign d66    = tneg ? -$signed({2'b0, r80[63:0]}) : $signed({2'b0, r80[63:0]});

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= prod[63:0];
		case (cmd.op)
			OP_LOAD: begin
				v_q[0] <= in_data[31:0];
				v_q[1] <= in_data[63:32];
				v_q[2] <= in_data[95:64];
				f_q[0] <= in_data[158:127];
				f_q[1] <= in_data[190:159];
				f_q[2] <= in_data[222:191];
				r_q[0] <= in_data[238:223];
				r_q[1] <= in_data[254:239];
				r_q[2] <= in_data[270:255];
				m_q    <= (mass == 31'd0) ? 31'd1 : mass;
				g_q    <= g_sel;
				last_q <= in_last;
				term_q <= '0;
				ss_q   <= '0;
			end
			OP_DIVQ: begin
				if (div_done) begin
					q_q   <= div_quot;
					rem_q <= div_rem[30:0];
				end
			end
			OP_DIVR: begin
				if (div_done) x_q <= (q_q > CAP_DIV6 || xs > CAP) ? CAP[46:0] : xs[46:0];
			end
			OP_SQRTC: begin
				if (sq_done) coeff_q <= sq_root[31] ? 31'h7FFF_FFFF : sq_root[30:0];
			end
			OP_GV: t1_q <= trunc_shift(prod_q, 15);
			OP_BD: begin
				bd_q[cmd.idx] <= (cmd.idx == 2'd2 && !cfg.mode_flags[MODE_3D]) ?
					32'sd0 : sat32(66'(diff));
			end
			OP_DIVA: begin
				if (div_done) a_q[cmd.idx] <= sat32(qa);
			end
			OP_VNEW: v_q[cmd.idx] <= sat32(66'(vi) + 66'(trunc_shift(prod_q, 17)));
			OP_TERM: term_q <= sat64(66'(term_q) + 66'(prod_q));
			OP_SS:   ss_q <= ss_q + prod_q;
			OP_SQRTS: begin
				if (sq_done) spd_q <= sq_root;
			end
			OP_DIVS: begin
				if (div_done) s_q <= div_quot[46:0];
			end
			OP_VSHI: acc_q <= prod_q;
			OP_MG:   mg_q <= acc_q + {prod_q[31:0], 32'b0};
			OP_DIVV: begin
				if (div_done) v_q[cmd.idx] <= vi[31] ? -vq32 : vq32;
			end
			OP_EDHI: acc_q <= prod_q;
			OP_EN:   done_q <= last_q && cfg.mode_flags[MODE_TALLY];
			OP_OUT: begin
				out_q <= {extra_q, reservoir_q, a_q[2], a_q[1], a_q[0],
					v_q[2], v_q[1], v_q[0]};
				out_user_q <= done_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transfer_q  <= '0;
			reservoir_q <= '0;
			extra_q     <= '0;
		end else begin
			case (cmd.op)
				OP_TRANS: begin
					if (cfg.mode_flags[MODE_TALLY])
						transfer_q <= sat64(66'(transfer_q) + 66'(term_q));
				end
				OP_EN: begin
					if (last_q) begin
						if (cfg.mode_flags[MODE_TALLY]) begin
							reservoir_q <= sat64(66'(reservoir_q) - d66);
							extra_q     <= trunc_shift(transfer_q, 1);
						end
						transfer_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign status.div_done  = div_done;
	assign status.sqrt_done = sq_done;
	assign status.exceed    = prod_q > {17'b0, cfg.limit_distance, 16'b0};
	assign status.limit_en  = cfg.mode_flags[MODE_LIMIT];
	assign status.tally_en  = cfg.mode_flags[MODE_TALLY];
	assign status.last      = last_q;

	assign out_data = out_q;
	assign out_user = out_user_q;

endmodule

// ===== hw/rtl/lvu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lvu_ctrl
// Sequencer for the per-particle update: steps the datapath through the
// friction coefficient, the three component loops, the speed limit and the
// end-of-step energy update, and owns both handshakes.
// ----------------------------------------------------------------------------
module lvu_ctrl
	import lvu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t status
);

	typedef enum logic [27:0] {
		S_IDLE  = 28'd1 << 0,  S_GT    = 28'd1 << 1,  S_DIVQ  = 28'd1 << 2,
		S_DIVR  = 28'd1 << 3,  S_SQRTC = 28'd1 << 4,  S_RC    = 28'd1 << 5,
		S_GV    = 28'd1 << 6,  S_BD    = 28'd1 << 7,  S_DIVA  = 28'd1 << 8,
		S_ADT   = 28'd1 << 9,  S_VNEW  = 28'd1 << 10, S_MTAL  = 28'd1 << 11,
		S_TERM  = 28'd1 << 12, S_TRANS = 28'd1 << 13, S_SQ    = 28'd1 << 14,
		S_SS    = 28'd1 << 15, S_SQRTS = 28'd1 << 16, S_SPD   = 28'd1 << 17,
		S_CMP   = 28'd1 << 18, S_DIVS  = 28'd1 << 19, S_VSLO  = 28'd1 << 20,
		S_VSHI  = 28'd1 << 21, S_MG    = 28'd1 << 22, S_DIVV  = 28'd1 << 23,
		S_EDLO  = 28'd1 << 24, S_EDHI  = 28'd1 << 25, S_EN    = 28'd1 << 26,
		S_OUT   = 28'd1 << 27
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic       started_q, started_d;
	logic       out_valid_q;
	logic       load_out;
	logic       wait_div, wait_sqrt, unit_done;
	logic       last_idx;
	state_t     after_lim;

	assign last_idx  = idx_q == 2'd2;
	assign after_lim = (status.last && status.tally_en) ? S_EDLO : S_EN;
	assign load_out  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		wait_div  = 1'b0;
		wait_sqrt = 1'b0;
		case (state_q)
			S_DIVQ, S_DIVR, S_DIVA, S_DIVS, S_DIVV: wait_div = 1'b1;
			S_SQRTC, S_SQRTS: wait_sqrt = 1'b1;
			default: ;
		endcase
	end

	assign unit_done = started_q && (wait_div ? status.div_done : status.sqrt_done);

	always_comb begin
		state_d        = state_q;
		idx_d          = idx_q;
		started_d      = started_q;
		cmd.op         = OP_NONE;
		cmd.idx        = idx_q;
		cmd.div_start  = 1'b0;
		cmd.sqrt_start = 1'b0;
		if (wait_div || wait_sqrt) begin
			if (!started_q) begin
				started_d      = 1'b1;
				cmd.div_start  = wait_div;
				cmd.sqrt_start = wait_sqrt;
			end else if (unit_done) begin
				started_d = 1'b0;
			end
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					idx_d   = 2'd0;
					state_d = S_GT;
				end
			end
			S_GT: begin
				cmd.op  = OP_GT;
				state_d = S_DIVQ;
			end
			S_DIVQ: begin
				cmd.op = OP_DIVQ;
				if (unit_done) state_d = S_DIVR;
			end
			S_DIVR: begin
				cmd.op = OP_DIVR;
				if (unit_done) state_d = S_SQRTC;
			end
			S_SQRTC: begin
				cmd.op = OP_SQRTC;
				if (unit_done) state_d = S_RC;
			end
			S_RC: begin
				cmd.op  = OP_RC;
				state_d = S_GV;
			end
			S_GV: begin
				cmd.op  = OP_GV;
				state_d = S_BD;
			end
			S_BD: begin
				cmd.op  = OP_BD;
				state_d = S_DIVA;
			end
			S_DIVA: begin
				cmd.op = OP_DIVA;
				if (unit_done) state_d = S_ADT;
			end
			S_ADT: begin
				cmd.op  = OP_ADT;
				state_d = S_VNEW;
			end
			S_VNEW: begin
				cmd.op  = OP_VNEW;
				state_d = S_MTAL;
			end
			S_MTAL: begin
				cmd.op  = OP_MTAL;
				state_d = S_TERM;
			end
			S_TERM: begin
				cmd.op = OP_TERM;
				if (last_idx) begin
					idx_d   = 2'd0;
					state_d = S_TRANS;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_RC;
				end
			end
			S_TRANS: begin
				cmd.op  = OP_TRANS;
				state_d = status.limit_en ? S_SQ : after_lim;
			end
			S_SQ: begin
				cmd.op  = OP_SQ;
				state_d = S_SS;
			end
			S_SS: begin
				cmd.op = OP_SS;
				if (last_idx) begin
					idx_d   = 2'd0;
					state_d = S_SQRTS;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_SQ;
				end
			end
			S_SQRTS: begin
				cmd.op = OP_SQRTS;
				if (unit_done) state_d = S_SPD;
			end
			S_SPD: begin
				cmd.op  = OP_SPD;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op  = OP_CMP;
				state_d = status.exceed ? S_DIVS : after_lim;
			end
			S_DIVS: begin
				cmd.op = OP_DIVS;
				if (unit_done) state_d = S_VSLO;
			end
			S_VSLO: begin
				cmd.op  = OP_VSLO;
				state_d = S_VSHI;
			end
			S_VSHI: begin
				cmd.op  = OP_VSHI;
				state_d = S_MG;
			end
			S_MG: begin
				cmd.op  = OP_MG;
				state_d = S_DIVV;
			end
			S_DIVV: begin
				cmd.op = OP_DIVV;
				if (unit_done) begin
					if (last_idx) begin
						idx_d   = 2'd0;
						state_d = after_lim;
					end else begin
						idx_d   = idx_q + 2'd1;
						state_d = S_VSLO;
					end
				end
			end
			S_EDLO: begin
				cmd.op  = OP_EDLO;
				state_d = S_EDHI;
			end
			S_EDHI: begin
				cmd.op  = OP_EDHI;
				state_d = S_EN;
			end
			S_EN: begin
				cmd.op  = OP_EN;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (load_out) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			started_q <= started_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/langevin_velocity_update_top.sv =====
// ----------------------------------------------------------------------------
// langevin_velocity_update_top
// Langevin thermostat second half-kick, one particle per request.
// ----------------------------------------------------------------------------
// One particle is processed at a time. An item takes longer when the speed
// limit rescales the velocity. Its processing time is set by the shared
// 64-step radix-2 divider (two divisions for the friction coefficient, one per
// acceleration component, and four more when limiting) and the 32-step square
// root unit. The next request is taken while the previous result waits in the
// output register. Configuration is held in registers written through the cfg
// channel, which is always ready.
// ----------------------------------------------------------------------------
module langevin_velocity_update_top
	import lvu_pkg::*;
#(
	parameter int NUM_TYPES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// vel_x, vel_y, vel_z, mass, force_x, force_y, force_z,
	// random_x, random_y, random_z, friction_source, zero pad
	input  logic [IN_W-1:0]   s_axis_tdata,
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// new_vel_x, new_vel_y, new_vel_z, accel_x, accel_y, accel_z,
	// reservoir_energy_out, extra_energy_out
	output logic [OUT_W-1:0]  m_axis_tdata,
	// step_done
	output logic              m_axis_tuser,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	cfg_t        cfg_q;
	logic [30:0] gamma_q [NUM_TYPES];
	cmd_t        cmd;
	status_t     status;
	logic        cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temperature    <= 31'd65536;
			cfg_q.time_step      <= 31'd328;
			cfg_q.limit_distance <= 31'd65536;
			cfg_q.mode_flags     <= 4'd1;
			for (int k = 0; k < NUM_TYPES; k++) gamma_q[k] <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMPERATURE: cfg_q.temperature    <= cfg_data[30:0];
				REG_TIME_STEP:   cfg_q.time_step      <= cfg_data[30:0];
				REG_LIMIT_DIST:  cfg_q.limit_distance <= cfg_data[30:0];
				REG_MODE_FLAGS:  cfg_q.mode_flags     <= cfg_data[3:0];
				default: begin
					for (int k = 0; k < NUM_TYPES; k++) begin
						if (cfg_index == 3'(int'(REG_GAMMA0) + k))
							gamma_q[k] <= cfg_data[30:0];
					end
				end
			endcase
		end
	end

	lvu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	lvu_datapath #(
		.NUM_TYPES (NUM_TYPES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg      (cfg_q),
		.gamma    (gamma_q),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);

endmodule

// ===== tb/langevin_velocity_update_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// langevin_velocity_update_top_tb
// Self-checking bench for the Langevin velocity half-kick block. A directed
// table covers reset state, field extremes and the special cases (bad type
// index, zero mass, zero time step, 2D mode, tally on and off at step end),
// then random phases with varied register settings follow. Every result is
// checked field by field against an in-bench fixed-point predictor, with
// random gaps and stalls on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module langevin_velocity_update_top_tb;
	import lvu_pkg::*;

	localparam longint LMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint LMIN = 64'sh8000_0000_0000_0000;
	localparam longint unsigned M31V = 64'h7FFF_FFFF;
	localparam longint unsigned CAPV = 64'h0000_4000_0000_0000;
	localparam int PHASE_ITEMS = 240;

	typedef struct packed {
		logic               last;
		logic [30:0]        src;
		logic signed [15:0] rz, ry, rx;
		logic signed [31:0] fz, fy, fx;
		logic [30:0]        mass;
		logic signed [31:0] vz, vy, vx;
	} particle_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] extra, resv;
		logic signed [31:0] az, ay, ax, nvz, nvy, nvx;
	} kick_t;

	typedef struct {
		logic       is_cfg;
		logic [2:0] idx;
		logic [31:0] cdata;
		particle_t  p;
		logic       zero_exp;
	} row_t;

	logic clk, arst_n;
	logic s_valid, s_last, m_ready, cfg_valid;
	logic [IN_W-1:0] s_data;
	logic [2:0] cfg_idx;
	logic [31:0] cfg_dat;
	logic s_axis_tready, m_axis_tvalid, m_axis_tuser, cfg_ready;
	logic [OUT_W-1:0] m_axis_tdata;

	longint unsigned cfg_temp, cfg_dt, cfg_lim;
	longint unsigned gam [4];
	logic [3:0] cfg_mode;
	longint transfer, resv_e, extra_e;

	kick_t kick_q [$];
	int errors, sent_cnt, hold_cnt;
	logic held, calm;

	langevin_velocity_update_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_valid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_data), .s_axis_tlast(s_last),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_ready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_idx), .cfg_data(cfg_dat)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(64'd150_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic longint unsigned isqrt(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint sadd(input longint a, input longint b);
		if (b > 0 && a > LMAX - b) return LMAX;
		if (b < 0 && a < LMIN - b) return LMIN;
		return a + b;
	endfunction

	function automatic longint sat32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint scale_dt(input longint v, input longint unsigned dt);
		longint unsigned mgn, hi, lo, lim, r, add;
		mgn = v < 0 ? 64'd0 - longint'(v) : longint'(v);
		hi = mgn >> 16;
		lo = mgn & 64'hFFFF;
		lim = v < 0 ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (hi != 0 && hi > lim / dt) r = lim;
		else begin
			r = hi * dt;
			add = (lo * dt) >> 16;
			r = (r > lim - add) ? lim : r + add;
		end
		if (v < 0) return r == 64'h8000_0000_0000_0000 ? LMIN : -longint'(r);
		return longint'(r);
	endfunction

	function automatic kick_t kick_predict(input particle_t p);
		longint v [3], f [3], r [3], bd [3], a [3];
		longint t1, t2, term, d;
		longint unsigned dt, m, g, gt, q, rm, x, coeff, ss, spd, s, mg;
		kick_t k;
		dt = cfg_dt != 0 ? cfg_dt : 1;
		m = p.mass != 0 ? p.mass : 1;
		v[0] = p.vx; v[1] = p.vy; v[2] = p.vz;
		f[0] = p.fx; f[1] = p.fy; f[2] = p.fz;
		r[0] = p.rx; r[1] = p.ry; r[2] = p.rz;
		if (cfg_mode[MODE_DIAM]) g = p.src;
		else g = p.src < 4 ? gam[p.src[1:0]] : 0;
		gt = g * cfg_temp;
		q = gt / dt;
		rm = gt % dt;
		if (q > CAPV / 6) x = CAPV;
		else begin
			x = 6 * q + (6 * rm) / dt;
			if (x > CAPV) x = CAPV;
		end
		coeff = isqrt(x << 16);
		if (coeff > M31V) coeff = M31V;
		for (int i = 0; i < 3; i++) begin
			t1 = (r[i] * longint'(coeff)) / 32768;
			t2 = (longint'(g) * v[i]) / 65536;
			bd[i] = sat32(t1 - t2);
		end
		if (!cfg_mode[MODE_3D]) bd[2] = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = sat32(((f[i] + bd[i]) * 65536) / longint'(m));
			v[i] = sat32(v[i] + (a[i] * longint'(dt)) / 131072);
		end
		if (cfg_mode[MODE_TALLY]) begin
			term = 0;
			for (int i = 0; i < 3; i++) term = sadd(term, bd[i] * v[i]);
			transfer = sadd(transfer, term);
		end
		if (cfg_mode[MODE_LIMIT]) begin
			ss = 0;
			for (int i = 0; i < 3; i++) begin
				mg = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
				ss += mg * mg;
			end
			spd = isqrt(ss);
			if (spd * dt > (cfg_lim << 16)) begin
				s = (cfg_lim << 16) / dt;
				for (int i = 0; i < 3; i++) begin
					mg = (v[i] < 0 ? longint'(-v[i]) : longint'(v[i])) * s / spd;
					v[i] = v[i] < 0 ? -longint'(mg) : longint'(mg);
				end
			end
		end
		k.done = 1'b0;
		if (p.last) begin
			if (cfg_mode[MODE_TALLY]) begin
				d = scale_dt(transfer, dt);
				resv_e = (d == LMIN) ? sadd(sadd(resv_e, LMAX), 1) : sadd(resv_e, -d);
				extra_e = transfer / 2;
				k.done = 1'b1;
			end
			transfer = 0;
		end
		k.nvx = v[0][31:0]; k.nvy = v[1][31:0]; k.nvz = v[2][31:0];
		k.ax = a[0][31:0]; k.ay = a[1][31:0]; k.az = a[2][31:0];
		k.resv = resv_e;
		k.extra = extra_e;
		return k;
	endfunction

	task automatic report(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0h want %0h", field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : mon
		kick_t got, want;
		if (arst_n && m_axis_tvalid && m_ready) begin
			got = {m_axis_tuser, m_axis_tdata};
			if (kick_q.size() == 0) report("unexpected result", 0, 0);
			else begin
				want = kick_q.pop_front();
				if (got.nvx !== want.nvx) report("new_vel_x", got.nvx, want.nvx);
				if (got.nvy !== want.nvy) report("new_vel_y", got.nvy, want.nvy);
				if (got.nvz !== want.nvz) report("new_vel_z", got.nvz, want.nvz);
				if (got.ax !== want.ax) report("accel_x", got.ax, want.ax);
				if (got.ay !== want.ay) report("accel_y", got.ay, want.ay);
				if (got.az !== want.az) report("accel_z", got.az, want.az);
				if (got.resv !== want.resv) report("reservoir_energy", got.resv, want.resv);
				if (got.extra !== want.extra) report("extra_energy", got.extra, want.extra);
				if (got.done !== want.done) report("step_done", got.done, want.done);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
			hold_cnt <= 0;
			held <= 1'b0;
		end else if (hold_cnt != 0) begin
			m_ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (!held && sent_cnt >= 300) begin
			held <= 1'b0 | 1'b1;
			hold_cnt <= 4000;
			m_ready <= 1'b0;
		end else if (calm) begin
			m_ready <= 1'b1;
		end else if ($urandom % 64 == 0) begin
			hold_cnt <= $urandom_range(20, 300);
			m_ready <= 1'b0;
		end else begin
			m_ready <= ($urandom % 4 != 0);
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom % 16;
		if (calm || r < 10) return 0;
		if (r < 15) return $urandom_range(1, 3);
		return $urandom_range(20, 200);
	endfunction

	function automatic logic signed [31:0] rnd_word();
		case ($urandom % 8)
			0: return $urandom;
			1: case ($urandom % 4)
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return 32'sh0;
				default: return -32'sd1;
			endcase
			default: return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
		endcase
	endfunction

	function automatic particle_t rnd_particle();
		particle_t p;
		p.vx = rnd_word(); p.vy = rnd_word(); p.vz = rnd_word();
		p.fx = rnd_word(); p.fy = rnd_word(); p.fz = rnd_word();
		p.rx = 16'($urandom); p.ry = 16'($urandom); p.rz = 16'($urandom);
		case ($urandom % 8)
			0: p.mass = 31'($urandom);
			1: p.mass = ($urandom % 2) ? 31'h7FFF_FFFF : 31'($urandom % 2);
			default: p.mass = $urandom_range(1 << 12, 1 << 20);
		endcase
		if (cfg_mode[MODE_DIAM])
			p.src = ($urandom % 4 == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
		else
			p.src = ($urandom % 8 == 0) ? 31'($urandom) : 31'($urandom_range(0, 4));
		p.last = ($urandom % 16 == 0);
		return p;
	endfunction

	function automatic logic [31:0] reg_val(input logic [2:0] idx, input int ph);
		if (ph == 1) return idx == REG_MODE_FLAGS ? 32'hF : 32'h7FFF_FFFF;
		if (ph == 2) begin
			if (idx == REG_TIME_STEP) return 32'd1;
			return 32'd0;
		end
		case (idx)
			REG_MODE_FLAGS: return ph == 0 ? 32'hF : $urandom % 16;
			REG_TIME_STEP: case ($urandom % 4)
				0: return $urandom;
				1: return 32'd328;
				default: return $urandom_range(1, 1 << 14);
			endcase
			default: case ($urandom % 4)
				0: return $urandom;
				1: return 32'd65536;
				default: return $urandom_range(0, 1 << 20);
			endcase
		endcase
	endfunction

	function automatic row_t item(input longint vx, vy, vz, mass, fx, fy, fz,
			rx, ry, rz, src, input bit lst);
		row_t w;
		w.is_cfg = 1'b0; w.idx = '0; w.cdata = '0; w.zero_exp = 1'b0;
		w.p.vx = vx[31:0]; w.p.vy = vy[31:0]; w.p.vz = vz[31:0];
		w.p.mass = mass[30:0];
		w.p.fx = fx[31:0]; w.p.fy = fy[31:0]; w.p.fz = fz[31:0];
		w.p.rx = rx[15:0]; w.p.ry = ry[15:0]; w.p.rz = rz[15:0];
		w.p.src = src[30:0];
		w.p.last = lst;
		return w;
	endfunction

	function automatic row_t cfg_row(input logic [2:0] idx, input logic [31:0] d);
		row_t w;
		w.is_cfg = 1'b1; w.idx = idx; w.cdata = d; w.p = '0; w.zero_exp = 1'b0;
		return w;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_idx <= idx;
		cfg_dat <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TEMPERATURE: cfg_temp = d[30:0];
			REG_TIME_STEP: cfg_dt = d[30:0];
			REG_LIMIT_DIST: cfg_lim = d[30:0];
			REG_MODE_FLAGS: cfg_mode = d[3:0];
			default: gam[idx - REG_GAMMA0] = d[30:0];
		endcase
	endtask

	task automatic send_particle(input particle_t p, input logic zero_exp, input int gap);
		kick_t k;
		s_valid <= 1'b1;
		s_data <= {2'b00, p[301:0]};
		s_last <= p.last;
		do @(posedge clk); while (!s_axis_tready);
		k = kick_predict(p);
		if (zero_exp) k = '0;
		kick_q.push_back(k);
		sent_cnt++;
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_valid <= 1'b0;
		while (kick_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	initial begin : stim
		row_t rows [$];
		arst_n = 1'b0;
		s_valid = 1'b0; s_last = 1'b0; s_data = '0;
		cfg_valid = 1'b0; cfg_idx = '0; cfg_dat = '0;
		errors = 0; sent_cnt = 0; calm = 1'b0;
		cfg_temp = 65536; cfg_dt = 328; cfg_lim = 65536; cfg_mode = 4'h1;
		foreach (gam[i]) gam[i] = 65536;
		transfer = 0; resv_e = 0; extra_e = 0;

		rows.push_back(item(0, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0));
		rows[0].zero_exp = 1'b1;
		rows.push_back(item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32767, 32767, 32767, 3, 0));
		rows.push_back(item(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 1,
			-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			-32768, -32768, -32768, 0, 0));
		rows.push_back(item(65536, -65536, 1000, 0, 4096, -4096, 77, 100, -100, 5, 1, 0));
		rows.push_back(item(65536, 2000, -3000, 65536, 500, 600, 700, 1234, -999, 42, 4, 0));
		rows.push_back(item(-5000, 7000, 123, 90000, -800, 900, 1, -32767, 32767, 1,
			31'h7FFF_FFFF, 0));
		rows.push_back(item(0, 0, 0, 65536, 65536, 0, 0, 0, 0, 0, 2, 0));
		rows.push_back(cfg_row(REG_MODE_FLAGS, 32'h8));
		rows.push_back(item(300000, -200000, 100000, 131072, 20000, -10000, 5000,
			20000, -15000, 30000, 1, 0));
		rows.push_back(item(-90000, 40000, 70000, 65536, -3000, 2000, 1000,
			-8000, 9000, -32768, 2, 1));
		rows.push_back(cfg_row(REG_LIMIT_DIST, 32'h0));
		rows.push_back(cfg_row(REG_MODE_FLAGS, 32'hF));
		rows.push_back(item(5000000, -4000000, 3000000, 65536, 100000, 0, -100000,
			1000, 2000, 3000, 65536, 0));
		rows.push_back(item(-700000, 800000, -900000, 200000, 1, 2, 3,
			-30000, 30000, -1, 31'h7FFF_FFFF, 1));
		rows.push_back(cfg_row(REG_TIME_STEP, 32'h0));
		rows.push_back(item(123456, -654321, 111111, 65536, 7777, -8888, 9999,
			4000, -4000, 16000, 65536, 1));
		rows.push_back(cfg_row(REG_TEMPERATURE, 32'hFFFF_FFFF));
		rows.push_back(cfg_row(REG_GAMMA0, 32'h7FFF_FFFF));
		rows.push_back(cfg_row(REG_MODE_FLAGS, 32'h0));
		rows.push_back(item(65536, 65536, 65536, 65536, 0, 0, 0, 32767, -32767, 100, 0, 0));
		rows.push_back(cfg_row(REG_MODE_FLAGS, 32'h4));
		rows.push_back(cfg_row(REG_TIME_STEP, 32'h7FFF_FFFF));
		rows.push_back(cfg_row(REG_LIMIT_DIST, 32'h7FFF_FFFF));
		rows.push_back(item(40000, -50000, 60000, 65536, 10, -20, 30, 100, 200, 300, 1, 1));
		rows.push_back(item(-1, 1, -1, 31'h7FFF_FFFF, -1, 1, -1, -1, 1, -1, 4, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_idle();
				write_reg(rows[i].idx, rows[i].cdata);
				cfg_valid <= 1'b0;
			end else send_particle(rows[i].p, rows[i].zero_exp, gap_len());
		end

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			for (logic [3:0] r = REG_TEMPERATURE; r <= REG_GAMMA0 + 3; r++)
				write_reg(r[2:0], reg_val(r[2:0], ph));
			cfg_valid <= 1'b0;
			calm = (ph == 3);
			repeat (PHASE_ITEMS) send_particle(rnd_particle(), 1'b0, gap_len());
		end

		wait_idle();
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lvu_pkg.sv
hw/rtl/lvu_div.sv
hw/rtl/lvu_sqrt.sv
hw/rtl/lvu_datapath.sv
hw/rtl/lvu_ctrl.sv
hw/rtl/langevin_velocity_update_top.sv
tb/langevin_velocity_update_top_tb.sv
